// ----- rtl/lzw_fixed_width_encoder_core_assert.svh -----
// Assertion macros for the LZW encoder core.
`ifndef LZW_FIXED_WIDTH_ENCODER_CORE_ASSERT_SVH
`define LZW_FIXED_WIDTH_ENCODER_CORE_ASSERT_SVH
`ifndef SYNTH
`define LZWFE_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("lzwfe assertion failed");
`define LZWFE_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("lzwfe assertion failed");
`else
`define LZWFE_ASSERT(lbl, clk, rst_n, prop)
`define LZWFE_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ----- rtl/lzwfe_pkg.sv -----
package lzwfe_pkg;
  localparam int SYM_W      = 7;
  localparam int CODE_W     = 12;
  localparam int NEXT_W     = CODE_W + 1;
  localparam int CFG_W      = 4;
  localparam int WIDTH_MIN  = 7;
  localparam int WIDTH_MAX  = CODE_W;
  localparam int FIRST_CODE = 128;
  localparam int DICT_DEPTH = 1 << CODE_W;
  localparam int ENT_W      = CODE_W + SYM_W;
  localparam int MAP_DEPTH  = 1 << ENT_W;
  localparam logic [CFG_W-1:0] WIDTH_RESET = CFG_W'(12);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAP,
    ST_ENT,
    ST_DECIDE,
    ST_FLUSH
  } ctrl_state_t;

  typedef struct packed {
    logic accept;
    logic map_rd;
    logic ent_rd;
    logic resolve;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic have_prefix;
    logic eom;
    logic hit;
    logic out_free;
  } status_t;
endpackage

// ----- rtl/lzwfe_if.sv -----
interface lzwfe_in_if;
  logic                        valid;
  logic                        ready;
  logic [lzwfe_pkg::SYM_W-1:0] symbol;
  logic                        end_of_message;
  modport source (output valid, symbol, end_of_message, input ready);
  modport sink (input valid, symbol, end_of_message, output ready);
endinterface

interface lzwfe_out_if;
  logic                         valid;
  logic                         ready;
  logic [lzwfe_pkg::CODE_W-1:0] code_word;
  logic                         last_code;
  modport source (output valid, code_word, last_code, input ready);
  modport sink (input valid, code_word, last_code, output ready);
endinterface

interface lzwfe_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [lzwfe_pkg::CFG_W-1:0] code_width;
  modport source (output valid, code_width, input ready);
  modport sink (input valid, code_width, output ready);
endinterface

// ----- rtl/lzwfe_ctrl.sv -----
module lzwfe_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_eom,
  output logic               in_ready,
  input  lzwfe_pkg::status_t status,
  output lzwfe_pkg::cmd_t    cmd
);
  import lzwfe_pkg::*;

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (!status.have_prefix) begin
            state_nxt = in_eom ? ST_FLUSH : ST_IDLE;
          end else begin
            state_nxt = ST_MAP;
          end
        end
      end
      ST_MAP: begin
        cmd.map_rd = 1'b1;
        state_nxt  = ST_ENT;
      end
      ST_ENT: begin
        cmd.ent_rd = 1'b1;
        state_nxt  = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (status.hit || status.out_free) begin
          cmd.resolve = 1'b1;
          state_nxt   = status.eom ? ST_FLUSH : ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (status.out_free) begin
          cmd.flush = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule

// ----- rtl/lzwfe_datapath.sv -----
`include "lzw_fixed_width_encoder_core_assert.svh"

module lzwfe_datapath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [lzwfe_pkg::SYM_W-1:0] in_symbol,
  input  logic                        in_eom,
  input  logic                        cfg_valid,
  input  logic [lzwfe_pkg::CFG_W-1:0] cfg_code_width,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic [lzwfe_pkg::CODE_W-1:0] out_code,
  output logic                        out_last,
  input  lzwfe_pkg::cmd_t             cmd,
  output lzwfe_pkg::status_t          status
);
  import lzwfe_pkg::*;

  logic [CODE_W-1:0] map_mem [MAP_DEPTH];
  logic [ENT_W-1:0]  ent_mem [DICT_DEPTH];

  logic [SYM_W-1:0]  sym_r;
  logic              eom_r;
  logic [CODE_W-1:0] prefix_r, prefix_nxt;
  logic [NEXT_W-1:0] next_free_r, next_free_nxt;
  logic              have_prefix_r, have_prefix_nxt;
  logic [CFG_W-1:0]  width_r;
  logic [CODE_W-1:0] map_q_r;
  logic [CODE_W-1:0] code_r;
  logic [ENT_W-1:0]  ent_q_r;
  logic              out_valid_r, out_valid_nxt;
  logic [CODE_W-1:0] out_code_r, out_code_nxt;
  logic              out_last_r, out_last_nxt;

  logic [CFG_W-1:0]  width_eff;
  logic [NEXT_W-1:0] limit;
  logic              hit;
  logic              out_free;
  logic              insert;

  always_comb begin
    if (width_r < CFG_W'(WIDTH_MIN)) begin
      width_eff = CFG_W'(WIDTH_MIN);
    end else if (width_r > CFG_W'(WIDTH_MAX)) begin
      width_eff = CFG_W'(WIDTH_MAX);
    end else begin
      width_eff = width_r;
    end
  end

  // map entries never written read as unknown; the entry check rejects them
  assign limit    = NEXT_W'(1) << width_eff;
  assign hit      = (code_r >= CODE_W'(FIRST_CODE)) && ({1'b0, code_r} < next_free_r) &&
                    (ent_q_r === {prefix_r, sym_r});
  assign out_free = !out_valid_r || out_ready;
  assign insert   = cmd.resolve && !hit && (next_free_r < limit);

  always_ff @(posedge clk) begin
    if (cmd.map_rd) begin
      map_q_r <= map_mem[{prefix_r, sym_r}];
    end
    if (cmd.ent_rd) begin
      ent_q_r <= ent_mem[map_q_r];
      code_r  <= map_q_r;
    end
    if (insert) begin
      map_mem[{prefix_r, sym_r}]         <= next_free_r[CODE_W-1:0];
      ent_mem[next_free_r[CODE_W-1:0]] <= {prefix_r, sym_r};
    end
  end

  always_comb begin
    prefix_nxt      = prefix_r;
    next_free_nxt   = next_free_r;
    have_prefix_nxt = have_prefix_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_code_nxt    = out_code_r;
    out_last_nxt    = out_last_r;
    if (cmd.accept && !have_prefix_r) begin
      prefix_nxt      = CODE_W'(in_symbol);
      have_prefix_nxt = 1'b1;
    end
    if (cmd.resolve) begin
      if (hit) begin
        prefix_nxt = code_r;
      end else begin
        out_valid_nxt = 1'b1;
        out_code_nxt  = prefix_r;
        out_last_nxt  = 1'b0;
        prefix_nxt    = CODE_W'(sym_r);
        if (insert) begin
          next_free_nxt = next_free_r + NEXT_W'(1);
        end
      end
    end
    if (cmd.flush) begin
      out_valid_nxt   = 1'b1;
      out_code_nxt    = prefix_r;
      out_last_nxt    = 1'b1;
      prefix_nxt      = '0;
      next_free_nxt   = NEXT_W'(FIRST_CODE);
      have_prefix_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prefix_r      <= '0;
      next_free_r   <= NEXT_W'(FIRST_CODE);
      have_prefix_r <= 1'b0;
      width_r       <= WIDTH_RESET;
      out_valid_r   <= 1'b0;
      eom_r         <= 1'b0;
    end else begin
      prefix_r      <= prefix_nxt;
      next_free_r   <= next_free_nxt;
      have_prefix_r <= have_prefix_nxt;
      out_valid_r   <= out_valid_nxt;
      if (cfg_valid) begin
        width_r <= cfg_code_width;
      end
      if (cmd.accept) begin
        eom_r <= in_eom;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sym_r <= in_symbol;
    end
    out_code_r <= out_code_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_code  = out_code_r;
  assign out_last  = out_last_r;

  assign status.have_prefix = have_prefix_r;
  assign status.eom         = eom_r;
  assign status.hit         = hit;
  assign status.out_free    = out_free;

  `LZWFE_ASSERT(a_miss_emits, clk, rst_n, cmd.resolve && !hit |=> out_valid_r && !out_last_r)
  `LZWFE_ASSERT(a_flush_clears, clk, rst_n, cmd.flush |=> !have_prefix_r && out_last_r && next_free_r == NEXT_W'(FIRST_CODE))
  `LZWFE_ASSERT(a_next_range, clk, rst_n, next_free_r >= NEXT_W'(FIRST_CODE) && next_free_r <= NEXT_W'(DICT_DEPTH))
  `LZWFE_ASSERT(a_emit_has_room, clk, rst_n, (cmd.flush || (cmd.resolve && !hit)) |-> out_free)
endmodule

// ----- rtl/lzw_fixed_width_encoder_core.sv -----
// LZW encoder, 7-bit characters, fixed code width (7..12 bits, reset 12).
// in_ch carries one character per item with an end_of_message flag;
// out_ch carries emitted codes, last_code set on the final code of a message.
// cfg_ch writes code_width; it is always ready; the user must write it only
// while idle, which the block does not enforce. A message's first character is
// just accepted; each later one then takes two dependent synchronous reads
// (pair-to-code map, then the code entry check) and a decide step that emits
// and inserts on a miss; end_of_message adds a flush step for the final code.
// One output register holds a finished code; the block keeps working while it
// waits and stalls only when it must emit a second code before the first is
// taken. Reset clears control state and sets code_width to 12; the dictionary
// needs no clearing pass since entries at or above the next free code are
// ignored, and end of message resets the next free code to 128.
module lzw_fixed_width_encoder_core (
  input logic          clk,
  input logic          rst_n,
  lzwfe_in_if.sink     in_ch,
  lzwfe_out_if.source  out_ch,
  lzwfe_cfg_if.sink    cfg_ch
);
  import lzwfe_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ch.ready = 1'b1;

  lzwfe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_eom   (in_ch.end_of_message),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  lzwfe_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_symbol      (in_ch.symbol),
    .in_eom         (in_ch.end_of_message),
    .cfg_valid      (cfg_ch.valid),
    .cfg_code_width (cfg_ch.code_width),
    .out_ready      (out_ch.ready),
    .out_valid      (out_ch.valid),
    .out_code       (out_ch.code_word),
    .out_last       (out_ch.last_code),
    .cmd            (cmd),
    .status         (status)
  );
endmodule
